// File: hw/rtl/sactl_pkg.sv
// Package for the set-associative cache tag store with LRU replacement.
// Holds geometry constants, derived widths, controller states and the
// command and status structs. It depends on nothing else.
package sactl_pkg;

	// Largest power of two not above v, as an exponent.
	function automatic int flog2(input longint v);
		int     n;
		longint x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int BLOCK_BYTES = 64;
	localparam int NUM_SETS    = 64;
	localparam int WAYS        = 4;
	localparam int ADDR_BITS   = 32;

	// Fixed field widths of the words on the two channels.
	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 7;
	localparam int WAYOUT_W  = 2;
	localparam int STAMP_W   = 32;

	localparam int AW_EFF    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - AW_EFF);
	localparam int OFF_BITS  = flog2(BLOCK_BYTES);
	localparam int TAG_SHIFT = flog2(longint'(BLOCK_BYTES) * longint'(NUM_SETS));
	localparam int TAG_W     = AW_EFF - TAG_SHIFT;
	localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAYS_P2   = 1 << $clog2(WAYS);
	localparam int LVLS      = $clog2(WAYS_P2);

	localparam logic KIND_CPU  = 1'b0;
	localparam logic KIND_FILL = 1'b1;

	typedef enum logic [0:0] {
		CT_IDLE,
		CT_LOOKUP
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the input word and read the set row
		logic commit;   // write the row back and load the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free; // output register can take a word this cycle
	} dp_status_t;

endpackage

// File: hw/rtl/sactl_if.sv
// Channel interfaces of the cache tag store: request words in, result words out.
// Depends on sactl_pkg for the field widths.
interface sactl_req_if;
	import sactl_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] address;
	logic [SIZE_W-1:0] req_size;

	modport source (output valid, output kind, output address, output req_size, input ready);
	modport sink   (input valid, input kind, input address, input req_size, output ready);
endinterface

interface sactl_rsp_if;
	import sactl_pkg::*;

	logic                valid;
	logic                ready;
	logic                to_memory;
	logic [ADDR_W-1:0]   out_address;
	logic [SIZE_W-1:0]   out_size;
	logic                hit;
	logic [WAYOUT_W-1:0] way_used;

	modport source (output valid, output to_memory, output out_address, output out_size,
		output hit, output way_used, input ready);
	modport sink   (input valid, input to_memory, input out_address, input out_size,
		input hit, input way_used, output ready);
endinterface

// File: hw/rtl/sactl_ctrl.sv
// Controller of the cache tag store: a two-state machine that sequences
// row read and write-back. Depends on sactl_pkg.
module sactl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sactl_pkg::dp_status_t status,
	output sactl_pkg::dp_cmd_t    cmd
);
	import sactl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CT_IDLE: begin
				if (in_valid) begin
					state_d = CT_LOOKUP;
				end
			end
			CT_LOOKUP: begin
				if (status.out_free) begin
					state_d = CT_IDLE;
				end
			end
			default: begin
				state_d = CT_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			CT_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			CT_LOOKUP: begin
				cmd.commit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: hw/rtl/sactl_dpath.sv
// Datapath of the cache tag store: input latch, tag and stamp row memories,
// valid bits, hit search, LRU victim tree, use counter and output register.
// Depends on sactl_pkg and the channel interfaces in sactl_if.sv.
module sactl_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	sactl_req_if.sink             req,
	sactl_rsp_if.source           rsp,
	input  sactl_pkg::dp_cmd_t    cmd,
	output sactl_pkg::dp_status_t status
);
	import sactl_pkg::*;

	// Latched input word.
	logic              kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;

	// Row memories, one row per set, way w in slice w.
	logic [WAYS*TAG_W-1:0]   tag_mem   [NUM_SETS];
	logic [WAYS*STAMP_W-1:0] stamp_mem [NUM_SETS];
	logic [WAYS*TAG_W-1:0]   tag_rd_q;
	logic [WAYS*STAMP_W-1:0] stamp_rd_q;
	logic [WAYS-1:0]         valid_q   [NUM_SETS];

	logic [STAMP_W-1:0] use_cnt_q;

	logic                out_valid_q;
	logic                out_to_mem_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [SIZE_W-1:0]   out_size_q;
	logic                out_hit_q;
	logic [WAYOUT_W-1:0] out_way_q;

	logic [ADDR_W-1:0] in_addr_m;
	logic [ADDR_W-1:0] in_sh;
	logic [SET_W-1:0]  in_set;
	logic [ADDR_W-1:0] cur_addr_m;
	logic [ADDR_W-1:0] cur_sh;
	logic [SET_W-1:0]  cur_set;
	logic [ADDR_W-1:0] cur_tag_sh;
	logic [TAG_W-1:0]  cur_tag;
	logic [WAYS-1:0]   row_valid;

	logic [WAYS-1:0]   hit_vec;
	logic              any_hit;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  vic_way;
	logic [WAY_W-1:0]  sel_way;
	logic              do_update;

	logic [STAMP_W-1:0] lv_stamp [LVLS+1][WAYS_P2];
	logic [WAY_W-1:0]   lv_idx   [LVLS+1][WAYS_P2];

	logic [WAYS*TAG_W-1:0]   new_tag_row;
	logic [WAYS*STAMP_W-1:0] new_stamp_row;
	logic [WAYS-1:0]         new_valid_row;

	// Set of the arriving word for the row read; set, tag and valid bits of the latched word.
	always_comb begin
		in_addr_m  = req.address & ADDR_MASK;
		in_sh      = in_addr_m >> OFF_BITS;
		in_set     = in_sh[SET_W-1:0] & SET_MASK;
		cur_addr_m = addr_q & ADDR_MASK;
		cur_sh     = cur_addr_m >> OFF_BITS;
		cur_set    = cur_sh[SET_W-1:0] & SET_MASK;
		cur_tag_sh = cur_addr_m >> TAG_SHIFT;
		cur_tag    = cur_tag_sh[TAG_W-1:0];
		row_valid  = valid_q[cur_set];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q     <= req.kind;
			addr_q     <= req.address;
			size_q     <= req.req_size;
			tag_rd_q   <= tag_mem[in_set];
			stamp_rd_q <= stamp_mem[in_set];
		end
		if (cmd.commit && do_update) begin
			stamp_mem[cur_set] <= new_stamp_row;
		end
		if (cmd.commit && kind_q == KIND_FILL) begin
			tag_mem[cur_set] <= new_tag_row;
		end
	end

	// Hit search, lowest way first.
	always_comb begin
		any_hit = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = row_valid[w] && (tag_rd_q[w*TAG_W +: TAG_W] == cur_tag);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				any_hit = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// Victim tree: smallest stamp wins, the lower index keeps ties.
	// A way that was never filled reads as stamp zero.
	always_comb begin
		for (int l = 0; l <= LVLS; l++) begin
			for (int i = 0; i < WAYS_P2; i++) begin
				lv_stamp[l][i] = '1;
				lv_idx[l][i]   = '0;
			end
		end
		for (int i = 0; i < WAYS_P2; i++) begin
			if (i < WAYS) begin
				lv_stamp[0][i] = row_valid[i] ? stamp_rd_q[i*STAMP_W +: STAMP_W] : '0;
			end
			lv_idx[0][i] = WAY_W'(i);
		end
		for (int l = 0; l < LVLS; l++) begin
			for (int i = 0; i < WAYS_P2 / 2; i++) begin
				if (i < (WAYS_P2 >> (l + 1))) begin
					if (lv_stamp[l][2*i+1] < lv_stamp[l][2*i]) begin
						lv_stamp[l+1][i] = lv_stamp[l][2*i+1];
						lv_idx[l+1][i]   = lv_idx[l][2*i+1];
					end else begin
						lv_stamp[l+1][i] = lv_stamp[l][2*i];
						lv_idx[l+1][i]   = lv_idx[l][2*i];
					end
				end
			end
		end
		vic_way = lv_idx[LVLS][0];
	end

	// Row updates for the chosen way.
	always_comb begin
		sel_way       = (kind_q == KIND_FILL && !any_hit) ? vic_way : hit_way;
		do_update     = (kind_q == KIND_FILL) || any_hit;
		new_tag_row   = tag_rd_q;
		new_stamp_row = stamp_rd_q;
		new_valid_row = row_valid;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == sel_way) begin
				new_tag_row[w*TAG_W +: TAG_W]       = cur_tag;
				new_stamp_row[w*STAMP_W +: STAMP_W] = use_cnt_q;
				new_valid_row[w]                    = 1'b1;
			end else if (!row_valid[w]) begin
				// Keep unfilled ways reading as zero once their row is written.
				new_stamp_row[w*STAMP_W +: STAMP_W] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_cnt_q <= '0;
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (cmd.commit) begin
			if (do_update) begin
				use_cnt_q <= use_cnt_q + STAMP_W'(1);
			end
			if (kind_q == KIND_FILL) begin
				valid_q[cur_set] <= new_valid_row;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_addr_q <= addr_q;
			if (kind_q == KIND_CPU && !any_hit) begin
				out_to_mem_q <= 1'b1;
				out_size_q   <= size_q;
				out_hit_q    <= 1'b0;
				out_way_q    <= '0;
			end else begin
				out_to_mem_q <= 1'b0;
				out_size_q   <= '0;
				out_hit_q    <= (kind_q == KIND_CPU);
				out_way_q    <= WAYOUT_W'(sel_way);
			end
		end
	end

	assign status.out_free = !out_valid_q || rsp.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.to_memory   = out_to_mem_q;
	assign rsp.out_address = out_addr_q;
	assign rsp.out_size    = out_size_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.way_used    = out_way_q;

endmodule

// File: hw/rtl/set_assoc_cache_tags_lru_core.sv
// Set-associative cache tag store with least-recently-used replacement.
// The set row is read at the edge that accepts a word; the result is registered when
// the lookup finishes, which waits while the output register holds an untaken result.
// A new word is taken only after the last is finished: the registered row read of the
// tag and stamp memories is followed by compare and write-back of the same row.
// Reset (arst_n low, asynchronous) clears all valid bits, the use counter and
// the controller at once; no clearing pass is needed and no word is pending.
module set_assoc_cache_tags_lru_core (
	input  logic        clk,
	input  logic        arst_n,
	sactl_req_if.sink   req,
	sactl_rsp_if.source rsp
);
	import sactl_pkg::*;

	// The controller alternates between taking a word (idle) and finishing it
	// (lookup). The finish waits only while the output register still holds a
	// result that the sink has not taken, so a new word is taken as soon as
	// the previous result sits in that register.
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;

	sactl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the row memories (tags and stamps, one row per set),
	// the valid bits in flip-flops, the hit search, the victim tree over the
	// stamps and the 32-bit wrapping use counter. Ways not yet filled read as
	// stamp zero through their cleared valid bits; the stamp store is not reset.
	sactl_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.status (status)
	);

	assign req.ready = in_ready;

endmodule

// File: hw/rtl/sactl_chk.sv
// Port-level checker for the cache tag store and its bind to the top level.
// Depends on sactl_pkg for field widths.
module sactl_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_to_memory,
	input logic [sactl_pkg::ADDR_W-1:0]   rsp_out_address,
	input logic [sactl_pkg::SIZE_W-1:0]   rsp_out_size,
	input logic                           rsp_hit,
	input logic [sactl_pkg::WAYOUT_W-1:0] rsp_way_used
);
	import sactl_pkg::*;

	// One word at a time: in the cycle after a word is taken, the block is not ready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous word in flight");

	// A forwarded miss carries no hit and no way.
	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_to_memory |-> !rsp_hit && rsp_way_used == '0)
		else $error("forwarded miss with hit or way set");

	// A result not forwarded to memory (a CPU hit or a fill) carries no size.
	a_answer_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_to_memory |-> rsp_out_size == '0)
		else $error("CPU answer with nonzero size");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_out_address))
		else $error("result address changed while stalled");

endmodule

bind set_assoc_cache_tags_lru_core sactl_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_to_memory   (rsp.to_memory),
	.rsp_out_address (rsp.out_address),
	.rsp_out_size    (rsp.out_size),
	.rsp_hit         (rsp.hit),
	.rsp_way_used    (rsp.way_used)
);
